FILE: hdl/pts_pkg.sv
// Shared types, constants and boot-table contents for the tone melody sequencer.
`timescale 1ns / 1ps

package pts_pkg;

  localparam int MELODY_COUNT     = 4;
  localparam int TONES_PER_MELODY = 10;
  localparam int TABLE_DEPTH      = MELODY_COUNT * TONES_PER_MELODY;
  localparam int ADDR_W           = $clog2(TABLE_DEPTH);
  localparam int MELODY_W         = $clog2(MELODY_COUNT + 1);
  localparam int SLOT_W           = 4;
  localparam int FREQ_W           = 16;
  localparam int TIME_W           = 16;
  localparam int WORD_W           = FREQ_W + TIME_W;
  localparam int RELOAD_W         = 16;
  localparam int PULSE_W          = 15;

  localparam int CLOCK_NUMERATOR  = 128 * 100000;
  localparam int NUM_W            = $clog2(CLOCK_NUMERATOR + 1);
  localparam int MIN_FREQ         = 100;

  localparam logic [MELODY_W-1:0] MELODY_NONE = {MELODY_W{1'b1}};
  localparam logic [RELOAD_W-1:0] RELOAD_RESET = {RELOAD_W{1'b1}};

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_PLAY  = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_NOP   = 2'd3
  } req_t;

  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] wdata;
  } mem_req_t;

  localparam int BOOT_COUNT = 10;
  localparam int BOOT_TONES [BOOT_COUNT][4] = '{
    '{0, 0, 1000, 100},
    '{1, 0, 100, 100}, '{1, 1, 50, 100}, '{1, 2, 25, 100},
    '{2, 0, 100, 100}, '{2, 1, 50, 100}, '{2, 2, 25, 100},
    '{3, 0, 700, 200}, '{3, 1, 1, 200}, '{3, 2, 1200, 200}
  };

  function automatic logic [ADDR_W-1:0] table_addr(input logic [MELODY_W-1:0] m,
                                                   input logic [SLOT_W-1:0] s);
    return ADDR_W'(int'(m) * TONES_PER_MELODY + int'(s));
  endfunction

  function automatic logic [WORD_W-1:0] boot_word(input logic [ADDR_W-1:0] idx);
    logic [WORD_W-1:0] w;
    w = '0;
    for (int i = 0; i < BOOT_COUNT; i++) begin
      if (BOOT_TONES[i][0] < MELODY_COUNT && BOOT_TONES[i][1] < TONES_PER_MELODY &&
          int'(idx) == BOOT_TONES[i][0] * TONES_PER_MELODY + BOOT_TONES[i][1]) begin
        w = {FREQ_W'(BOOT_TONES[i][2]), TIME_W'(BOOT_TONES[i][3])};
      end
    end
    return w;
  endfunction

endpackage

FILE: hdl/pts_table_mem.sv
// Melody table memory: single port, registered read, boot contents until written.
`timescale 1ns / 1ps

module pts_table_mem (
  input  logic                        clk,
  input  logic                        rst,
  input  pts_pkg::mem_req_t           req,
  output logic [pts_pkg::WORD_W-1:0]  rd_data
);

  logic [pts_pkg::WORD_W-1:0]      mem [pts_pkg::TABLE_DEPTH];
  logic [pts_pkg::TABLE_DEPTH-1:0] written;
  logic [pts_pkg::WORD_W-1:0]      mem_q;
  logic                            written_q;
  logic [pts_pkg::ADDR_W-1:0]      addr_q;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      mem_q  <= mem[req.addr];
      addr_q <= req.addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written   <= '0;
      written_q <= 1'b0;
    end else begin
      if (req.wr_en) begin
        written[req.addr] <= 1'b1;
      end
      if (req.rd_en) begin
        written_q <= written[req.addr];
      end
    end
  end

  assign rd_data = written_q ? mem_q : pts_pkg::boot_word(addr_q);

endmodule

FILE: hdl/pts_divider.sv
// Bit-serial restoring divider: clock numerator over tone frequency.
`timescale 1ns / 1ps

module pts_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pts_pkg::FREQ_W-1:0]  divisor,
  output logic                        done,
  output logic [pts_pkg::NUM_W-1:0]   quotient
);

  localparam int CNT_W = $clog2(pts_pkg::NUM_W + 1);

  logic [pts_pkg::FREQ_W-1:0] dvs;
  logic [pts_pkg::FREQ_W-1:0] rem;
  logic [pts_pkg::NUM_W-1:0]  num_sr;
  logic [CNT_W-1:0]           cnt;
  logic                       busy;
  logic [pts_pkg::FREQ_W:0]   trial;
  logic                       fits;

  assign trial = {rem, num_sr[pts_pkg::NUM_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(pts_pkg::NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs      <= divisor;
      rem      <= '0;
      num_sr   <= pts_pkg::NUM_W'(pts_pkg::CLOCK_NUMERATOR);
      quotient <= '0;
    end else if (busy) begin
      rem      <= fits ? pts_pkg::FREQ_W'(trial - {1'b0, dvs}) : trial[pts_pkg::FREQ_W-1:0];
      num_sr   <= {num_sr[pts_pkg::NUM_W-2:0], 1'b0};
      quotient <= {quotient[pts_pkg::NUM_W-2:0], fits};
    end
  end

endmodule

FILE: hdl/pwm_tone_melody_sequencer.sv
// Top level: tone melody sequencer control, table memory and period divider.
`timescale 1ns / 1ps
//
// One input channel (in_valid/in_ready) carries a transaction of one of four
// kinds: a one-millisecond tick, a play request for a melody, a table write
// or a no-op. Every accepted transaction yields exactly one result
// transaction on the output channel (out_valid/out_ready) showing PWM state,
// reload, compare, melody-done and current slot.
// Items are handled one at a time. A write, a plain tick or an ignored request
// goes straight to the result state; an item that reads the table first
// passes the table read state, and one that starts a tone of 100 Hz or more
// then waits in the divide state for the bit-serial period division.
// in_ready returns together with out_valid. The result sits in an output
// register, so the next transaction is accepted while the previous result
// still waits; if the receiver stalls longer, the block holds the new result
// internally and in_ready stays low.
// Reset (rst, synchronous) stops the PWM, deselects the melody, sets the
// reload to all ones and restores the built-in melodies in the table.
//
module pwm_tone_melody_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [1:0]  melody_sel,
  input  logic [3:0]  slot_sel,
  input  logic [15:0] tone_freq,
  input  logic [15:0] tone_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        pwm_on,
  output logic [15:0] period_reload,
  output logic [14:0] compare_pulse,
  output logic        melody_done,
  output logic [3:0]  playing_slot
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_WORD = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [pts_pkg::MELODY_W-1:0] cur_melody, cur_melody_next;
  logic [pts_pkg::SLOT_W-1:0]   tone_slot, tone_slot_next;
  logic [pts_pkg::SLOT_W-1:0]   slot_hold, slot_hold_next;
  logic [pts_pkg::TIME_W-1:0]   ms_left, ms_left_next;
  logic                         timing_active, timing_active_next;
  logic                         pwm_running, pwm_running_next;
  logic [pts_pkg::RELOAD_W-1:0] reload_reg, reload_reg_next;
  logic [pts_pkg::PULSE_W-1:0]  pulse_reg, pulse_reg_next;
  logic                         done_flag, done_flag_next;
  logic                         from_tick, from_tick_next;

  pts_pkg::mem_req_t            mreq;
  logic [pts_pkg::WORD_W-1:0]   rd_data;
  logic [pts_pkg::FREQ_W-1:0]   rd_freq;
  logic                         div_start;
  logic                         div_done;
  logic [pts_pkg::NUM_W-1:0]    div_q;
  logic [pts_pkg::SLOT_W:0]     slot_inc;
  logic                         out_load;
  logic [pts_pkg::MELODY_W-1:0] msel_ext;

  pts_table_mem u_table (
    .clk     (clk),
    .rst     (rst),
    .req     (mreq),
    .rd_data (rd_data)
  );

  pts_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (rd_freq),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_ready = (state == ST_IDLE);
  assign rd_freq  = rd_data[pts_pkg::WORD_W-1:pts_pkg::TIME_W];
  assign slot_inc = {1'b0, tone_slot} + 1'b1;
  assign msel_ext = pts_pkg::MELODY_W'(melody_sel);
  assign out_load = (state == ST_DONE) && (!out_valid || out_ready);

  always_comb begin
    state_next         = state;
    cur_melody_next    = cur_melody;
    tone_slot_next     = tone_slot;
    slot_hold_next     = slot_hold;
    ms_left_next       = ms_left;
    timing_active_next = timing_active;
    pwm_running_next   = pwm_running;
    reload_reg_next    = reload_reg;
    pulse_reg_next     = pulse_reg;
    done_flag_next     = done_flag;
    from_tick_next     = from_tick;
    mreq               = '0;
    div_start          = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          done_flag_next = 1'b0;
          from_tick_next = 1'b0;
          state_next     = ST_DONE;
          unique case (pts_pkg::req_t'(req_type))
            pts_pkg::REQ_TICK: begin
              if (timing_active) begin
                if (ms_left != '0) begin
                  ms_left_next = ms_left - 1'b1;
                end else begin
                  pwm_running_next   = 1'b0;
                  timing_active_next = 1'b0;
                  ms_left_next       = '0;
                  if (int'(cur_melody) < pts_pkg::MELODY_COUNT) begin
                    if (int'(slot_inc) >= pts_pkg::TONES_PER_MELODY) begin
                      tone_slot_next = '0;
                      done_flag_next = 1'b1;
                    end else begin
                      mreq.rd_en     = 1'b1;
                      mreq.addr      = pts_pkg::table_addr(cur_melody,
                                         slot_inc[pts_pkg::SLOT_W-1:0]);
                      slot_hold_next = slot_inc[pts_pkg::SLOT_W-1:0];
                      from_tick_next = 1'b1;
                      state_next     = ST_WORD;
                    end
                  end
                end
              end
            end
            pts_pkg::REQ_PLAY: begin
              if (int'(melody_sel) < pts_pkg::MELODY_COUNT) begin
                tone_slot_next  = '0;
                cur_melody_next = msel_ext;
                mreq.rd_en      = 1'b1;
                mreq.addr       = pts_pkg::table_addr(msel_ext, '0);
                state_next      = ST_WORD;
              end
            end
            pts_pkg::REQ_WRITE: begin
              if (int'(melody_sel) < pts_pkg::MELODY_COUNT &&
                  int'(slot_sel) < pts_pkg::TONES_PER_MELODY) begin
                mreq.wr_en = 1'b1;
                mreq.addr  = pts_pkg::table_addr(msel_ext, slot_sel);
                mreq.wdata = {tone_freq, tone_time};
              end
            end
            pts_pkg::REQ_NOP: begin
            end
          endcase
        end
      end
      ST_WORD: begin
        state_next = ST_DONE;
        if (from_tick && rd_freq == '0) begin
          tone_slot_next = '0;
          done_flag_next = 1'b1;
        end else begin
          if (from_tick) begin
            tone_slot_next = slot_hold;
          end
          if (rd_freq != '0) begin
            pwm_running_next   = 1'b1;
            timing_active_next = 1'b1;
            ms_left_next       = rd_data[pts_pkg::TIME_W-1:0];
            if (int'(rd_freq) >= pts_pkg::MIN_FREQ) begin
              div_start  = 1'b1;
              state_next = ST_DIV;
            end
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          reload_reg_next = div_q[pts_pkg::RELOAD_W-1:0] - 1'b1;
          pulse_reg_next  = reload_reg_next[pts_pkg::RELOAD_W-1:1];
          state_next      = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cur_melody    <= pts_pkg::MELODY_NONE;
      tone_slot     <= '0;
      slot_hold     <= '0;
      ms_left       <= '0;
      timing_active <= 1'b0;
      pwm_running   <= 1'b0;
      reload_reg    <= pts_pkg::RELOAD_RESET;
      pulse_reg     <= '0;
      done_flag     <= 1'b0;
      from_tick     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      cur_melody    <= cur_melody_next;
      tone_slot     <= tone_slot_next;
      slot_hold     <= slot_hold_next;
      ms_left       <= ms_left_next;
      timing_active <= timing_active_next;
      pwm_running   <= pwm_running_next;
      reload_reg    <= reload_reg_next;
      pulse_reg     <= pulse_reg_next;
      done_flag     <= done_flag_next;
      from_tick     <= from_tick_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pwm_on        <= pwm_running;
      period_reload <= reload_reg;
      compare_pulse <= pulse_reg;
      melody_done   <= done_flag;
      playing_slot  <= tone_slot;
    end
  end

endmodule

FILE: hdl/pts_checker.sv
// Port-level checks for the tone melody sequencer, bound to the top level.
`timescale 1ns / 1ps

module pts_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        pwm_on,
  input logic [15:0] period_reload,
  input logic [14:0] compare_pulse,
  input logic        melody_done,
  input logic [3:0]  playing_slot
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(period_reload) &&
      $stable(compare_pulse) && $stable(playing_slot) && $stable(pwm_on) &&
      $stable(melody_done))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");

  a_done_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && melody_done |-> !pwm_on && playing_slot == 4'd0)
    else $error("melody end with pwm running or slot not cleared");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> int'(playing_slot) < pts_pkg::TONES_PER_MELODY)
    else $error("slot out of range");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind pwm_tone_melody_sequencer pts_checker u_pts_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .pwm_on        (pwm_on),
  .period_reload (period_reload),
  .compare_pulse (compare_pulse),
  .melody_done   (melody_done),
  .playing_slot  (playing_slot)
);
